// ----- sv/qskv_pkg.sv -----
// ----------------------------------------------------------------------------
// qskv_pkg: shared types and constants for the query string key/value extractor
// Character codes, the classified byte record passed from the front end to
// the back end, key configuration bundle and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package qskv_pkg;

  // sizes
  localparam int MAX_KEY_BYTES = 8;
  localparam int VALUE_BITS    = 32;
  localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_W    = 1;
  localparam int FIFO_CNT_W    = 2;
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int PROD_W        = VALUE_BITS + 4;

  localparam logic [VALUE_BITS-1:0] VALUE_HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

  // register index codes, taken from paddr[3]
  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // one classified input byte
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       delim;
    logic       digit;
    logic [3:0] dval;
    logic       space;
    logic       plus;
    logic       minus;
  } item_t;

  // key setup seen by the back end
  typedef struct packed {
    logic [MAX_KEY_BYTES-1:0][7:0] key;
    logic [KEY_POS_W-1:0]          klen;
  } key_cfg_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_VALUE  = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    DG_PRE  = 3'b001,
    DG_NUM  = 3'b010,
    DG_STOP = 3'b100
  } digit_phase_t;

endpackage

`default_nettype wire

// ----- sv/qskv_if.sv -----
// ----------------------------------------------------------------------------
// qskv_if: stream channels of the query string key/value extractor
// Input byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qskv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface qskv_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic signed [qskv_pkg::VALUE_BITS-1:0] value;
  logic                                  saturated;

  modport source (output valid, output found, output value, output saturated, input ready);
  modport sink   (input valid, input found, input value, input saturated, output ready);
endinterface

`default_nettype wire

// ----- sv/qskv_front.sv -----
// ----------------------------------------------------------------------------
// qskv_front: input stage
// Takes one byte per beat and classifies it (delimiter, digit, blank,
// sign) before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qskv_front (
  qskv_in_if.sink               in_ch,
  input  qskv_pkg::fifo_stat_t  stat,
  output logic                  push,
  output qskv_pkg::item_t       push_item
);

  logic [7:0] ch;

  assign ch = in_ch.byte_in;

  // accept whenever the queue has room
  assign in_ch.ready = !stat.full;
  assign push        = in_ch.valid && !stat.full;

  // byte classification
  always_comb begin
    push_item.ch    = ch;
    push_item.last  = in_ch.last;
    push_item.delim = (ch == qskv_pkg::CH_SPACE) || (ch == qskv_pkg::CH_NL) ||
                      (ch == qskv_pkg::CH_EQ)    || (ch == qskv_pkg::CH_AMP);
    push_item.digit = (ch >= qskv_pkg::CH_ZERO) && (ch <= qskv_pkg::CH_NINE);
    push_item.dval  = 4'(ch - qskv_pkg::CH_ZERO);
    push_item.space = (ch == qskv_pkg::CH_TAB) || (ch == qskv_pkg::CH_CR) ||
                      (ch == qskv_pkg::CH_VT)  || (ch == qskv_pkg::CH_FF);
    push_item.plus  = (ch == qskv_pkg::CH_PLUS);
    push_item.minus = (ch == qskv_pkg::CH_MINUS);
  end

endmodule

`default_nettype wire

// ----- sv/qskv_fifo.sv -----
// ----------------------------------------------------------------------------
// qskv_fifo: classified byte queue
// Small queue between front and back end; push and pop may happen in the
// same cycle, so one beat per cycle flows through while it is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module qskv_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  qskv_pkg::item_t       push_item,
  input  logic                  pop,
  output qskv_pkg::item_t       head,
  output qskv_pkg::fifo_stat_t  stat
);

  qskv_pkg::item_t                     mem [qskv_pkg::FIFO_DEPTH];
  logic [qskv_pkg::FIFO_PTR_W-1:0]     wr_ptr;
  logic [qskv_pkg::FIFO_PTR_W-1:0]     rd_ptr;
  logic [qskv_pkg::FIFO_CNT_W-1:0]     count;

  assign stat.full  = (count == qskv_pkg::FIFO_CNT_W'(qskv_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full && !pop)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty)) else $error("queue pop while empty");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qskv_pkg::FIFO_CNT_W'(qskv_pkg::FIFO_DEPTH))
    else $error("queue level out of range");

endmodule

`default_nettype wire

// ----- sv/qskv_back.sv -----
// ----------------------------------------------------------------------------
// qskv_back: key match and value conversion
// Pops classified bytes, tracks the key match per token, converts the
// token after the key atoi-style and registers the result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qskv_back (
  input  logic                  clk,
  input  logic                  rst,
  input  qskv_pkg::key_cfg_t    cfg,
  input  qskv_pkg::fifo_stat_t  stat,
  input  qskv_pkg::item_t       head,
  output logic                  pop,
  qskv_out_if.source            out_ch
);

  localparam int VB = qskv_pkg::VALUE_BITS;
  localparam int PW = qskv_pkg::PROD_W;

  // string state
  qskv_pkg::phase_t                  phase, phase_next;
  qskv_pkg::digit_phase_t            dphase, dphase_next;
  logic [qskv_pkg::KEY_POS_W-1:0]    char_pos, char_pos_next;
  logic                              tok_match, tok_match_next;
  logic [VB-1:0]                     acc, acc_next;
  logic                              neg, neg_next;
  logic                              clamp, clamp_next;

  // result register
  logic                              out_valid;
  logic                              out_found;
  logic [VB-1:0]                     out_value;
  logic                              out_sat;

  logic [VB-1:0]                     limit;
  logic [PW-1:0]                     prod;
  logic                              over;
  logic [7:0]                        key_ch;
  logic                              pos_ok;

  // only a byte marked last has to wait for the result register
  assign pop = !stat.empty && (!head.last || !out_valid || out_ch.ready);

  assign out_ch.valid     = out_valid;
  assign out_ch.found     = out_found;
  assign out_ch.value     = out_value;
  assign out_ch.saturated = out_sat;

  // times-ten step and overflow check
  assign limit  = neg ? qskv_pkg::VALUE_HALF : qskv_pkg::VALUE_HALF - 1'b1;
  assign prod   = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(head.dval);
  assign over   = prod > PW'(limit);
  assign pos_ok = char_pos < cfg.klen;
  assign key_ch = cfg.key[char_pos[qskv_pkg::KEY_IDX_W-1:0]];

  // next state for one byte
  always_comb begin
    phase_next     = phase;
    dphase_next    = dphase;
    char_pos_next  = char_pos;
    tok_match_next = tok_match;
    acc_next       = acc;
    neg_next       = neg;
    clamp_next     = clamp;
    case (phase)
      qskv_pkg::PH_SEARCH: begin
        if (!head.delim) begin
          if (tok_match && pos_ok && (head.ch == key_ch)) begin
            char_pos_next = char_pos + 1'b1;
          end else begin
            tok_match_next = 1'b0;
          end
        end
        if (head.delim || head.last) begin
          if (tok_match_next && (char_pos_next == cfg.klen)) begin
            phase_next = qskv_pkg::PH_VALUE;
          end
          char_pos_next  = '0;
          tok_match_next = 1'b1;
        end
      end
      qskv_pkg::PH_VALUE: begin
        if (head.delim) begin
          phase_next = qskv_pkg::PH_DONE;
        end else if (dphase != qskv_pkg::DG_STOP) begin
          if (head.digit) begin
            dphase_next = qskv_pkg::DG_NUM;
            if (over) begin
              acc_next   = limit;
              clamp_next = 1'b1;
            end else begin
              acc_next = prod[VB-1:0];
            end
          end else if (dphase == qskv_pkg::DG_PRE && head.space) begin
            dphase_next = dphase;
          end else if (dphase == qskv_pkg::DG_PRE && (head.plus || head.minus)) begin
            neg_next    = head.minus;
            dphase_next = qskv_pkg::DG_NUM;
          end else begin
            dphase_next = qskv_pkg::DG_STOP;
          end
        end
      end
      qskv_pkg::PH_DONE: begin
        phase_next = phase;
      end
      default: begin
        phase_next = qskv_pkg::PH_SEARCH;
      end
    endcase
  end

  // state update, cleared after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= qskv_pkg::PH_SEARCH;
      dphase    <= qskv_pkg::DG_PRE;
      char_pos  <= '0;
      tok_match <= 1'b1;
      acc       <= '0;
      neg       <= 1'b0;
      clamp     <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        phase     <= qskv_pkg::PH_SEARCH;
        dphase    <= qskv_pkg::DG_PRE;
        char_pos  <= '0;
        tok_match <= 1'b1;
        acc       <= '0;
        neg       <= 1'b0;
        clamp     <= 1'b0;
      end else begin
        phase     <= phase_next;
        dphase    <= dphase_next;
        char_pos  <= char_pos_next;
        tok_match <= tok_match_next;
        acc       <= acc_next;
        neg       <= neg_next;
        clamp     <= clamp_next;
      end
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      if (phase_next != qskv_pkg::PH_SEARCH) begin
        out_found <= 1'b1;
        out_value <= neg_next ? (VB'(0) - acc_next) : acc_next;
        out_sat   <= clamp_next;
      end else begin
        out_found <= 1'b0;
        out_value <= '0;
        out_sat   <= 1'b0;
      end
    end
  end

  a_search_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == qskv_pkg::PH_SEARCH) |->
      (dphase == qskv_pkg::DG_PRE && acc == '0 && !clamp && !neg))
    else $error("conversion state dirty while searching");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    clamp |-> (acc == limit)) else $error("clamped magnitude not at limit");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    char_pos <= cfg.klen || phase != qskv_pkg::PH_SEARCH)
    else $error("match position past key length");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(out_valid) && out_valid) |-> $past(pop && head.last))
    else $error("result without last byte");

endmodule

`default_nettype wire

// ----- sv/query_string_key_value_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// query_string_key_value_extractor_unit: query string key lookup
// Finds the first token equal to a configured key and returns the
// atoi-style value of the token that follows it.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while its queue has room, and
// keeps no limit on string length. A byte is classified on entry and placed
// in a two-entry queue; the back end matches and converts one byte per
// cycle, but a byte marked last waits while an earlier result is still held
// on the output. A result beat is driven from an output register from the
// cycle after the byte marked last is taken. Input keeps flowing while a
// result waits on the output, up to the next byte marked last.
// Registers (64-bit APB): key_bytes at 0x0, first character in bits 7..0;
// key_length at 0x8, values above 8 act as 8. Write them only while no
// string is in flight. Values beyond the signed 32-bit range are clamped
// and flagged with saturated.
`default_nettype none

module query_string_key_value_extractor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qskv_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [qskv_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [qskv_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  qskv_in_if.sink                             in_ch,
  qskv_out_if.source                          out_ch
);

  logic [qskv_pkg::CFG_DATA_W-1:0] key_bytes;
  logic [3:0]                      key_length;
  logic                            reg_sel;
  logic                            wr_en;

  qskv_pkg::key_cfg_t              cfg;
  qskv_pkg::fifo_stat_t            stat;
  qskv_pkg::item_t                 push_item;
  qskv_pkg::item_t                 head;
  logic                            push;
  logic                            pop;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;
  assign prdata  = (reg_sel == qskv_pkg::REG_KEY_LENGTH) ?
                   qskv_pkg::CFG_DATA_W'(key_length) : key_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= 4'd1;
    end else if (wr_en) begin
      case (reg_sel)
        qskv_pkg::REG_KEY_BYTES:  key_bytes  <= pwdata;
        qskv_pkg::REG_KEY_LENGTH: key_length <= pwdata[3:0];
        default:                  key_length <= key_length;
      endcase
    end
  end

  // effective key
  assign cfg.key  = key_bytes[8*qskv_pkg::MAX_KEY_BYTES-1:0];
  assign cfg.klen = (key_length > 4'(qskv_pkg::MAX_KEY_BYTES)) ?
                    qskv_pkg::KEY_POS_W'(qskv_pkg::MAX_KEY_BYTES) :
                    qskv_pkg::KEY_POS_W'(key_length);

  qskv_front u_front (
    .in_ch     (in_ch),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  qskv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  qskv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stat   (stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for query_string_key_value_extractor_unit
// Streams query strings one byte per beat and checks every result beat
// against a typed expectation or an in-bench model of the key match and
// the value conversion. A short table of hand-written strings goes first,
// then random strings built around the configured key, under random source
// gaps, sink stalls and a long sink hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 75;
  localparam int NUM_PHASES   = 8;
  localparam logic [7:0] NUL_MARK = 8'h7E;  // '~' in the table stands for a NUL byte

  typedef struct packed {
    logic              found;
    logic signed [31:0] value;
    logic              saturated;
  } result_t;

  typedef struct {
    string   key;
    int      klen;
    string   text;
    bit      typed;
    result_t want;
  } case_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [qskv_pkg::CFG_ADDR_W-1:0] paddr;
  logic [qskv_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  qskv_in_if  in_ch ();
  qskv_out_if out_ch ();

  query_string_key_value_extractor_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copy and lookup state of the model
  logic [63:0]            key_reg;
  logic [3:0]             klen_reg;
  qskv_pkg::phase_t       scan_phase;
  logic [3:0]             match_pos;
  logic                   token_ok;
  logic [63:0]            magnitude;
  logic                   negative;
  qskv_pkg::digit_phase_t digit_state;
  logic                   clamped;

  result_t pending_results[$];
  result_t table_want;
  bit      table_typed;
  case_t   cases[$];
  logic [7:0] query_bytes[$];

  int err_count   = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;
  bit have_result;
  result_t scan_result;
  result_t got_want;

  function automatic bit is_delim(input logic [7:0] b);
    return b == qskv_pkg::CH_SPACE || b == qskv_pkg::CH_NL ||
           b == qskv_pkg::CH_EQ    || b == qskv_pkg::CH_AMP;
  endfunction

  function automatic void clear_scan();
    scan_phase  = qskv_pkg::PH_SEARCH;
    match_pos   = '0;
    token_ok    = 1'b1;
    magnitude   = '0;
    negative    = 1'b0;
    digit_state = qskv_pkg::DG_PRE;
    clamped     = 1'b0;
  endfunction

  // one byte through key match and value conversion
  task automatic scan_char(input logic [7:0] b, input logic fin, output bit has_res,
                           output result_t res);
    logic [3:0]  klen;
    logic [63:0] d, lim;
    logic [31:0] m32;
    bit          dl;
    klen = (klen_reg > qskv_pkg::MAX_KEY_BYTES) ? 4'(qskv_pkg::MAX_KEY_BYTES) : klen_reg;
    dl = is_delim(b);
    has_res = 1'b0;
    res = '0;
    if (scan_phase == qskv_pkg::PH_SEARCH) begin
      if (!dl) begin
        if (token_ok && match_pos < klen && b == key_reg[8*match_pos +: 8])
          match_pos = match_pos + 4'd1;
        else
          token_ok = 1'b0;
      end
      if (dl || fin) begin
        if (token_ok && match_pos == klen)
          scan_phase = qskv_pkg::PH_VALUE;
        match_pos = '0;
        token_ok  = 1'b1;
      end
    end else if (scan_phase == qskv_pkg::PH_VALUE) begin
      if (dl) begin
        scan_phase = qskv_pkg::PH_DONE;
      end else if (digit_state != qskv_pkg::DG_STOP) begin
        // atoi: blanks, one sign, then digits up to the first other byte
        if (b >= qskv_pkg::CH_ZERO && b <= qskv_pkg::CH_NINE) begin
          d = 64'(b - qskv_pkg::CH_ZERO);
          lim = negative ? 64'(qskv_pkg::VALUE_HALF) : 64'(qskv_pkg::VALUE_HALF) - 64'd1;
          digit_state = qskv_pkg::DG_NUM;
          if (magnitude > (lim - d) / 64'd10) begin
            magnitude = lim;
            clamped   = 1'b1;
          end else begin
            magnitude = magnitude * 64'd10 + d;
          end
        end else if (digit_state == qskv_pkg::DG_PRE &&
                     (b == qskv_pkg::CH_TAB || b == qskv_pkg::CH_CR ||
                      b == qskv_pkg::CH_VT  || b == qskv_pkg::CH_FF)) begin
          digit_state = qskv_pkg::DG_PRE;
        end else if (digit_state == qskv_pkg::DG_PRE &&
                     (b == qskv_pkg::CH_PLUS || b == qskv_pkg::CH_MINUS)) begin
          negative    = (b == qskv_pkg::CH_MINUS);
          digit_state = qskv_pkg::DG_NUM;
        end else begin
          digit_state = qskv_pkg::DG_STOP;
        end
      end
    end
    if (fin) begin
      has_res = 1'b1;
      if (scan_phase != qskv_pkg::PH_SEARCH) begin
        m32 = magnitude[31:0];
        res.found     = 1'b1;
        res.value     = negative ? (32'd0 - m32) : m32;
        res.saturated = clamped;
      end
      clear_scan();
    end
  endtask

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      scan_char(in_ch.byte_in, in_ch.last, have_result, scan_result);
      if (have_result)
        pending_results.push_back(table_typed ? table_want : scan_result);
    end
  end

  task automatic report_mismatch(input string field, input longint want, input longint got);
    err_count++;
    if (err_count <= 10)
      $display("%s mismatch: expected %0d, got %0d", field, want, got);
  endtask

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("result beat with nothing pending: found %0b value %0d saturated %0b",
                   out_ch.found, out_ch.value, out_ch.saturated);
      end else begin
        got_want = pending_results.pop_front();
        if (out_ch.found !== got_want.found)
          report_mismatch("found", got_want.found, out_ch.found);
        if (out_ch.value !== got_want.value)
          report_mismatch("value", $signed(got_want.value), $signed(out_ch.value));
        if (out_ch.saturated !== got_want.saturated)
          report_mismatch("saturated", got_want.saturated, out_ch.saturated);
      end
    end
  end

  // sink: changing stall patterns, plus one long hold-off on request
  initial begin : sink_stalls
    int mode, span;
    logic [7:0] mask;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 80);
      mask = 8'($urandom) | 8'h01;
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          out_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: begin
            out_ch.ready = mask[0];
            mask = {mask[0], mask[7:1]};
          end
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("query_string_key_value_extractor_unit test failed");
    $finish;
  end

  // source: bursts of random length with random gaps
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.byte_in = b;
    in_ch.last    = fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_in();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // stop sending and let every pending result out
  task automatic drain();
    pause_in();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == qskv_pkg::REG_KEY_BYTES)
      key_reg = data;
    else
      klen_reg = data[3:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [7:0] table_byte(input string t, input int i);
    return (t[i] == NUL_MARK) ? 8'h00 : t[i];
  endfunction

  function automatic logic [63:0] pack_key(input string k);
    logic [63:0] kb;
    kb = '0;
    for (int i = 0; i < k.len() && i < 8; i++)
      kb[8*i +: 8] = table_byte(k, i);
    return kb;
  endfunction

  function automatic void add_case(input string key, input int klen, input string text,
                                   input bit typed, input bit f, input logic [31:0] v,
                                   input bit s);
    case_t c;
    c.key   = key;
    c.klen  = klen;
    c.text  = text;
    c.typed = typed;
    c.want.found     = f;
    c.want.value     = v;
    c.want.saturated = s;
    cases.push_back(c);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_delim(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_delim();
    case ($urandom_range(0, 3))
      0: return qskv_pkg::CH_SPACE;
      1: return qskv_pkg::CH_NL;
      2: return qskv_pkg::CH_EQ;
      default: return qskv_pkg::CH_AMP;
    endcase
  endfunction

  // value token: optional blanks and signs, digits in most cases, sometimes junk after
  task automatic add_number();
    int sel, nd;
    string near_max;
    near_max = "214748364";
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
      case ($urandom_range(0, 3))
        0: query_bytes.push_back(qskv_pkg::CH_TAB);
        1: query_bytes.push_back(qskv_pkg::CH_CR);
        2: query_bytes.push_back(qskv_pkg::CH_VT);
        default: query_bytes.push_back(qskv_pkg::CH_FF);
      endcase
    end
    sel = $urandom_range(0, 7);
    if (sel == 0 || sel == 2)
      query_bytes.push_back(qskv_pkg::CH_PLUS);
    if (sel == 1 || sel == 2)
      query_bytes.push_back(qskv_pkg::CH_MINUS);
    sel = $urandom_range(0, 19);
    if (sel < 17) begin
      nd = (sel < 14) ? $urandom_range(1, 5) : $urandom_range(9, 12);
      repeat (nd) query_bytes.push_back(qskv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (sel < 19) begin
      for (int i = 0; i < near_max.len(); i++)
        query_bytes.push_back(near_max[i]);
      query_bytes.push_back(qskv_pkg::CH_ZERO + 8'($urandom_range(6, 9)));
    end
    if ($urandom_range(0, 3) == 0)
      query_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // random query string built around the current key
  task automatic build_query();
    int ntok, kind, kl, n;
    query_bytes.delete();
    kl = (klen_reg > qskv_pkg::MAX_KEY_BYTES) ? qskv_pkg::MAX_KEY_BYTES : int'(klen_reg);
    ntok = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // key, possibly as the final token
        for (int i = 0; i < kl; i++)
          query_bytes.push_back(key_reg[8*i +: 8]);
        if ($urandom_range(0, 4) == 0)
          break;
        query_bytes.push_back(rand_delim());
        add_number();
      end else if (kind < 6) begin
        // key prefix or key with an extra byte
        n = $urandom_range(0, kl);
        for (int i = 0; i < n; i++)
          query_bytes.push_back(key_reg[8*i +: 8]);
        if (n == kl || $urandom_range(0, 1) == 1)
          query_bytes.push_back(rand_plain());
      end else if (kind < 8) begin
        repeat ($urandom_range(0, 3)) query_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_number();
      end
      if (t < ntok - 1 || $urandom_range(0, 3) == 0) begin
        query_bytes.push_back(rand_delim());
        if ($urandom_range(0, 4) == 0)
          query_bytes.push_back(rand_delim());
      end
    end
    if (query_bytes.size() == 0)
      query_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin : main
    logic [63:0] kb;
    int kl, sent;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.byte_in = '0;
    in_ch.last = 1'b0;
    table_typed = 1'b0;
    table_want = '0;
    key_reg = '0;
    klen_reg = 4'd1;
    clear_scan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // hand-written strings, expectations typed where obvious
    add_case("id", 2, "id=42", 1, 1, 42, 0);
    add_case("id", 2, "a=1&id=-17", 1, 1, -17, 0);
    add_case("id", 2, "x=5", 1, 0, 0, 0);
    add_case("id", 2, "q=id", 1, 1, 0, 0);
    add_case("id", 2, "id&", 1, 1, 0, 0);
    add_case("", 0, "ab=", 1, 0, 0, 0);
    add_case("", 0, "=7", 1, 1, 7, 0);
    add_case("abcdefgh", 15, "abcdefgh=9", 1, 1, 9, 0);
    add_case("a~", 2, "a~=3", 1, 1, 3, 0);
    add_case("v", 1, "v=2147483648", 1, 1, 32'h7FFF_FFFF, 1);
    add_case("v", 1, "v=2147483647", 1, 1, 32'h7FFF_FFFF, 0);
    add_case("v", 1, "v=-2147483648", 1, 1, 32'h8000_0000, 0);
    add_case("v", 1, "v=-99999999999", 1, 1, 32'h8000_0000, 1);
    add_case("v", 1, "v=\t\015\013\014+12x5", 1, 1, 12, 0);
    add_case("v", 1, "v=\n5", 1, 1, 0, 0);
    add_case("v", 1, "v=-", 1, 1, 0, 0);
    add_case("v", 1, "v=+-3", 1, 1, 0, 0);
    add_case("v", 1, "v=1 v=2", 1, 1, 1, 0);
    add_case("v", 1, "v=5~6", 1, 1, 5, 0);
    add_case("v", 1, "7", 1, 0, 0, 0);
    add_case("v", 1, "v", 1, 1, 0, 0);
    add_case("v", 1, "v=0007", 0, 0, 0, 0);
    add_case("v", 1, "k=12&v=34", 0, 0, 0, 0);
    add_case("ab", 2, "abc=1&ab=2", 1, 1, 2, 0);
    add_case("\377\377\377\377\377\377\377\377", 8, "\377\377\377\377\377\377\377\377=\377",
             1, 1, 0, 0);

    foreach (cases[c]) begin
      kb = pack_key(cases[c].key);
      if (kb != key_reg || 4'(cases[c].klen) != klen_reg) begin
        drain();
        if (kb != key_reg)
          write_reg(qskv_pkg::REG_KEY_BYTES, kb);
        if (4'(cases[c].klen) != klen_reg)
          write_reg(qskv_pkg::REG_KEY_LENGTH, 64'(cases[c].klen));
      end
      pause_in();
      table_typed = cases[c].typed;
      table_want  = cases[c].want;
      for (int i = 0; i < cases[c].text.len(); i++)
        send_beat(table_byte(cases[c].text, i), i == cases[c].text.len() - 1);
    end
    pause_in();
    table_typed = 1'b0;

    // random strings, one key setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      kb = '0;
      for (int i = 0; i < 8; i++)
        kb[8*i +: 8] = rand_plain();
      case (ph)
        0: kl = 1;
        1: kl = 8;
        2: begin
          kl = 0;
          kb = {$urandom, $urandom};
        end
        3: kl = 15;
        4: begin
          kl = 3;
          kb = '0;
        end
        5: begin
          kl = 8;
          kb = '1;
        end
        6: begin
          kl = $urandom_range(1, 8);
          kb = {$urandom, $urandom};
        end
        default: kl = $urandom_range(9, 14);
      endcase
      write_reg(qskv_pkg::REG_KEY_BYTES, kb);
      write_reg(qskv_pkg::REG_KEY_LENGTH, 64'(kl));

      // long sink hold-off while one-byte strings keep coming
      if (ph == 3) begin
        hold_req = 1'b1;
        repeat (30) send_beat(8'($urandom_range(0, 255)), 1'b1);
      end

      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_query();
        foreach (query_bytes[i])
          send_beat(query_bytes[i], i == query_bytes.size() - 1);
        sent += query_bytes.size();
      end
    end

    pause_in();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("query_string_key_value_extractor_unit test passed");
    else
      $display("query_string_key_value_extractor_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
